FILE: src/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared sizes, codes and types for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int NUM_PAGES  = 65536;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_W     = 16;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] ADDR_FIRST_PAGE = CFG_ADDR_W'(0);

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = PAGE_W'(1048576 / 4096);

  typedef logic [WORD_BITS-1:0] map_word_t;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_SET_USABLE = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } op_t;

endpackage

FILE: src/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit physical page allocator over occupancy and usable bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/in_* and are taken when start is high and busy is
//   low. Ops: allocate, free page, set usable flag, clear all occupancy.
//   Every command returns one result on out_ok/out_page_index, marked by a
//   one-cycle out_strobe; the receiver cannot stall, so results are never held.
//   Steps from acceptance to the result:
//     free / set usable : read word, write back, result
//     allocate          : read word, scan words from first_page's word up to
//                         the hit, one word per cycle (max 1024), set the hit
//                         bit, result; with no page found, result after last word
//     clear all         : one occupancy word cleared per cycle
//   busy falls with out_strobe, so the next command can be taken at the edge
//   that takes the result. The scan rate is set by the single read port of
//   each bitmap memory.
//   Both bitmaps are 1024 x 64-bit memories. After reset a clearing pass zeroes
//   them; busy stays high until it ends. The APB register first_page (reset 256)
//   may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_op,
  input  logic [pba_pkg::PAGE_W-1:0]     in_page_number,
  input  logic                           in_usable_flag,
  // result channel
  output logic                           out_strobe,
  output logic                           out_ok,
  output logic [pba_pkg::PAGE_W-1:0]     out_page_index,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pba_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pba_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pba_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int WB = pba_pkg::WORD_BITS;
  localparam int BW = pba_pkg::BIT_IDX_W;
  localparam int AW = pba_pkg::WORD_IDX_W;
  localparam int PW = pba_pkg::PAGE_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(pba_pkg::MAP_WORDS - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_RD, ST_CHK, ST_FIND, ST_MOD, ST_CLR
  } state_t;

  state_t             state_r, state_nxt;
  pba_pkg::op_t       op_r, op_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [BW-1:0]      bit_r, bit_nxt;
  logic               flag_r, flag_nxt;
  pba_pkg::map_word_t hit_r, hit_nxt;
  pba_pkg::map_word_t occ_r, occ_nxt;
  logic [PW-1:0]      first_page_r;

  logic               out_strobe_r, out_strobe_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [PW-1:0]      out_page_index_r, out_page_index_nxt;

  // memory ports
  logic               occ_we, usa_we;
  logic [AW-1:0]      occ_waddr, usa_waddr, raddr;
  pba_pkg::map_word_t occ_wdata, usa_wdata, occ_rdata, usa_rdata;

  pba_pkg::map_word_t cand, low_mask, bit_mask;
  logic [BW-1:0]      hit_idx;
  logic               cfg_wr;

  pba_ram #(.WIDTH(WB), .DEPTH(pba_pkg::MAP_WORDS)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (raddr),
    .rdata (occ_rdata)
  );

  pba_ram #(.WIDTH(WB), .DEPTH(pba_pkg::MAP_WORDS)) u_usa_ram (
    .clk   (clk),
    .we    (usa_we),
    .waddr (usa_waddr),
    .wdata (usa_wdata),
    .raddr (raddr),
    .rdata (usa_rdata)
  );

  // configuration port
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr == pba_pkg::ADDR_FIRST_PAGE) ?
                  pba_pkg::CFG_DATA_W'(first_page_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= pba_pkg::FIRST_PAGE_RESET;
    end else if (cfg_wr) begin
      first_page_r <= pwdata[PW-1:0];
    end
  end

  // candidates in the word just read; bits below first_page are masked
  // only in the word that holds first_page
  always_comb begin
    low_mask = '1;
    if (addr_r == first_page_r[PW-1:BW]) begin
      low_mask = low_mask << first_page_r[BW-1:0];
    end
    cand = usa_rdata & ~occ_rdata & low_mask;
  end

  // one-hot of the lowest hit to its bit index
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (hit_r[i]) begin
        hit_idx = hit_idx | BW'(i);
      end
    end
  end

  assign bit_mask = pba_pkg::map_word_t'(1) << bit_r;

  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    addr_nxt           = addr_r;
    bit_nxt            = bit_r;
    flag_nxt           = flag_r;
    hit_nxt            = hit_r;
    occ_nxt            = occ_r;
    out_strobe_nxt     = 1'b0;
    out_ok_nxt         = out_ok_r;
    out_page_index_nxt = out_page_index_r;

    raddr     = addr_r;
    occ_we    = 1'b0;
    occ_waddr = addr_r;
    occ_wdata = '0;
    usa_we    = 1'b0;
    usa_waddr = addr_r;
    usa_wdata = '0;

    unique case (state_r)
      ST_INIT: begin
        occ_we = 1'b1;
        usa_we = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_nxt   = pba_pkg::op_t'(in_op);
          bit_nxt  = in_page_number[BW-1:0];
          flag_nxt = in_usable_flag;
          unique case (pba_pkg::op_t'(in_op))
            pba_pkg::OP_ALLOC: begin
              addr_nxt  = first_page_r[PW-1:BW];
              state_nxt = ST_RD;
            end
            pba_pkg::OP_FREE, pba_pkg::OP_SET_USABLE: begin
              addr_nxt  = in_page_number[PW-1:BW];
              state_nxt = ST_RD;
            end
            pba_pkg::OP_CLEAR_ALL: begin
              addr_nxt  = '0;
              state_nxt = ST_CLR;
            end
            default: ;
          endcase
        end
      end

      ST_RD: begin
        state_nxt = (op_r == pba_pkg::OP_ALLOC) ? ST_CHK : ST_MOD;
      end

      ST_CHK: begin
        // next word is fetched while this one is checked
        raddr = addr_r + AW'(1);
        if (cand != '0) begin
          hit_nxt   = cand & (~cand + pba_pkg::map_word_t'(1));
          occ_nxt   = occ_rdata;
          state_nxt = ST_FIND;
        end else if (addr_r == LAST_WORD) begin
          out_strobe_nxt     = 1'b1;
          out_ok_nxt         = 1'b0;
          out_page_index_nxt = '0;
          state_nxt          = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      ST_FIND: begin
        occ_we             = 1'b1;
        occ_wdata          = occ_r | hit_r;
        out_strobe_nxt     = 1'b1;
        out_ok_nxt         = 1'b1;
        out_page_index_nxt = PW'({addr_r, hit_idx});
        state_nxt          = ST_IDLE;
      end

      ST_MOD: begin
        if (op_r == pba_pkg::OP_FREE) begin
          occ_we    = 1'b1;
          occ_wdata = occ_rdata & ~bit_mask;
        end else begin
          usa_we    = 1'b1;
          usa_wdata = flag_r ? (usa_rdata | bit_mask) : (usa_rdata & ~bit_mask);
        end
        out_strobe_nxt     = 1'b1;
        out_ok_nxt         = 1'b1;
        out_page_index_nxt = '0;
        state_nxt          = ST_IDLE;
      end

      ST_CLR: begin
        occ_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == LAST_WORD) begin
          out_strobe_nxt     = 1'b1;
          out_ok_nxt         = 1'b1;
          out_page_index_nxt = '0;
          state_nxt          = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      addr_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    op_r             <= op_nxt;
    bit_r            <= bit_nxt;
    flag_r           <= flag_nxt;
    hit_r            <= hit_nxt;
    occ_r            <= occ_nxt;
    out_ok_r         <= out_ok_nxt;
    out_page_index_r <= out_page_index_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_ok         = out_ok_r;
  assign out_page_index = out_page_index_r;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed allocate / free / set-usable / clear-all command
// sequences through page_bitmap_allocator. first_page moves between phases
// over APB. Every result is checked against a bitmap predictor inside the
// bench.
// ----------------------------------------------------------------------------
module testbench;
  import pba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] FIRST_PAGE_ADDR = ADDR_FIRST_PAGE;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct {
    op_t               op;
    logic [PAGE_W-1:0] page;
    logic              flag;
    bit                drain;   // sender waits for all outstanding results first
  } page_cmd_t;

  typedef struct {
    logic              ok;
    logic [PAGE_W-1:0] page;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = 2'd0;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic in_usable_flag = 1'b0;
  logic out_strobe;
  logic out_ok;
  logic [PAGE_W-1:0] out_page_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  page_bitmap_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_page_number (in_page_number),
    .in_usable_flag (in_usable_flag),
    .out_strobe     (out_strobe),
    .out_ok         (out_ok),
    .out_page_index (out_page_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk = ~clk;

  // Predictor state
  logic [WORD_BITS-1:0] occupied_words [MAP_WORDS];
  logic [WORD_BITS-1:0] usable_words [MAP_WORDS];
  logic [PAGE_W-1:0]    first_page_cfg = FIRST_PAGE_RESET;

  page_cmd_t    pending_cmds[$];
  page_result_t expected_results[$];
  page_cmd_t    cur_cmd;
  page_result_t exp_res;
  int           gap_left = 0;
  bit           gaps_on = 1'b1;
  int           n_errors = 0;
  int           quiet_cycles = 0;

  function automatic page_result_t predict_result(page_cmd_t c);
    page_result_t r;
    logic [WORD_BITS-1:0] cand;
    int w;
    int b;
    int pg;
    bit found;
    r.ok = 1'b1;
    r.page = '0;
    found = 1'b0;
    case (c.op)
      OP_ALLOC: begin
        for (w = int'(first_page_cfg) / WORD_BITS; w < MAP_WORDS && !found; w++) begin
          cand = usable_words[w] & ~occupied_words[w];
          if (cand != '0) begin
            for (b = 0; b < WORD_BITS && !found; b++) begin
              pg = w * WORD_BITS + b;
              if (cand[b] && pg >= int'(first_page_cfg) && pg < NUM_PAGES) begin
                found = 1'b1;
                r.page = PAGE_W'(pg);
              end
            end
          end
        end
        if (found) occupied_words[int'(r.page) / WORD_BITS][int'(r.page) % WORD_BITS] = 1'b1;
        else r.ok = 1'b0;
      end
      OP_FREE: begin
        if (int'(c.page) < NUM_PAGES)
          occupied_words[int'(c.page) / WORD_BITS][int'(c.page) % WORD_BITS] = 1'b0;
      end
      OP_SET_USABLE: begin
        if (int'(c.page) < NUM_PAGES)
          usable_words[int'(c.page) / WORD_BITS][int'(c.page) % WORD_BITS] = c.flag;
      end
      default: begin
        for (w = 0; w < MAP_WORDS; w++) occupied_words[w] = '0;
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  // Command driver: a transaction is taken at an edge with start high and busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_result(cur_cmd));
        gap_left = pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          in_op <= cur_cmd.op;
          in_page_number <= cur_cmd.page;
          in_usable_flag <= cur_cmd.flag;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: ok %0d page_index %0d", out_ok, out_page_index);
        n_errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_ok !== exp_res.ok) begin
          $error("out_ok mismatch: expected %0d, got %0d", exp_res.ok, out_ok);
          n_errors++;
        end
        if (out_page_index !== exp_res.page) begin
          $error("out_page_index mismatch: expected %0d, got %0d", exp_res.page,
                 out_page_index);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(input op_t op, input int page, input logic flag, input bit drain);
    page_cmd_t c;
    c.op = op;
    c.page = PAGE_W'(page);
    c.flag = flag;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic read_first_page();
    logic [CFG_DATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FIRST_PAGE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DATA_W'(first_page_cfg)) begin
      $error("first_page readback mismatch: expected %0d, got %0d", first_page_cfg, got);
      n_errors++;
    end
  endtask

  task automatic write_first_page(input logic [PAGE_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FIRST_PAGE_ADDR;
    pwdata <= {16'($urandom()), value};   // upper bits must be ignored
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    first_page_cfg = value;
    read_first_page();
  endtask

  // Random commands clustered around the search start so allocations mostly hit
  task automatic run_random_phase(input logic [PAGE_W-1:0] first, input int count,
                                  input bit with_gaps);
    int base;
    int pg;
    int r;
    op_t op;
    write_first_page(first);
    gaps_on = with_gaps;
    base = (int'(first) < NUM_PAGES - 256) ? int'(first) : NUM_PAGES - 256;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 35) op = OP_ALLOC;
      else if (r < 57) op = OP_FREE;
      else if (r < 97) op = OP_SET_USABLE;
      else op = OP_CLEAR_ALL;
      if ($urandom_range(99) < 15) begin
        pg = int'($urandom_range(NUM_PAGES - 1));
      end else begin
        pg = base - 32 + int'($urandom_range(287));
        if (pg < 0) pg = 0;
        if (pg > NUM_PAGES - 1) pg = NUM_PAGES - 1;
      end
      push_cmd(op, pg, ($urandom_range(99) < 80), ($urandom_range(99) < 2));
    end
    wait_idle();
  endtask

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      occupied_words[w] = '0;
      usable_words[w] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);   // post-reset clearing pass
    read_first_page();

    // Directed: empty map, edge pages, double free, usable revoke, clear-all
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_SET_USABLE, 0, 1'b1, 1'b0);
    push_cmd(OP_SET_USABLE, 255, 1'b1, 1'b0);
    push_cmd(OP_SET_USABLE, 256, 1'b1, 1'b0);
    push_cmd(OP_SET_USABLE, 257, 1'b1, 1'b0);
    push_cmd(OP_SET_USABLE, 65535, 1'b1, 1'b0);
    push_cmd(OP_ALLOC, 65535, 1'b1, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b1);
    push_cmd(OP_FREE, 257, 1'b0, 1'b0);
    push_cmd(OP_FREE, 257, 1'b1, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_SET_USABLE, 256, 1'b0, 1'b0);
    push_cmd(OP_FREE, 256, 1'b0, 1'b0);
    push_cmd(OP_CLEAR_ALL, 65535, 1'b1, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_ALLOC, 0, 1'b0, 1'b0);
    push_cmd(OP_SET_USABLE, 16'hFFFF, 1'b0, 1'b0);
    push_cmd(OP_SET_USABLE, 16'hAAAA, 1'b1, 1'b0);
    push_cmd(OP_SET_USABLE, 16'h5555, 1'b0, 1'b0);
    push_cmd(OP_FREE, 0, 1'b0, 1'b0);
    push_cmd(OP_FREE, 16'hFFFF, 1'b1, 1'b0);
    wait_idle();

    run_random_phase(16'd0, 110, 1'b0);
    run_random_phase(16'hFFFF, 40, 1'b1);
    run_random_phase(PAGE_W'($urandom_range(NUM_PAGES - 2, 1)), 110, 1'b1);
    run_random_phase(16'd65000, 50, 1'b0);
    run_random_phase(FIRST_PAGE_RESET, 120, 1'b1);
    run_random_phase(16'd0, 90, 1'b1);

    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
